// ===== rtl/pfe_pkg.sv =====
// Shared types and codes for the protobuf field extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pfe_pkg;

  // result kinds
  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // done status codes
  localparam logic [1:0] STATUS_CLEAN    = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN  = 2'd1;
  localparam logic [1:0] STATUS_BAD_WIRE = 2'd2;
  localparam logic [1:0] STATUS_MID      = 2'd3;

  // register indexes on the APB port
  localparam logic REG_FIRST_FIELD  = 1'b0;
  localparam logic REG_SECOND_FIELD = 1'b1;

  // one classified byte: an optional field result and an optional done result
  typedef struct packed {
    logic       has_field;
    logic [1:0] kind;
    logic       sel;
    logic [7:0] content;
    logic       first;
    logic       last;
    logic       has_done;
    logic [1:0] status;
  } pfe_entry_t;

  // one output beat
  typedef struct packed {
    logic [1:0] kind;
    logic       sel;
    logic [7:0] content;
    logic       first;
    logic       last;
    logic [1:0] status;
  } pfe_beat_t;

endpackage

`default_nettype wire

// ===== rtl/pfe_front.sv =====
// Front end: accepts body bytes, walks the wire format and classifies each byte.
// Depends on pfe_pkg; pushes one entry per byte that causes a result.
`default_nettype none

module pfe_front #(
  parameter int MAX_MESSAGE_BYTES = 8388608,
  parameter int MAX_VARINT_BYTES  = 10
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_fire,
  input  wire  [7:0]             data_byte,
  input  wire                    message_start,
  input  wire  [23:0]            message_length,
  input  wire  [31:0]            first_field_number,
  input  wire  [31:0]            second_field_number,
  output logic                   push,
  output pfe_pkg::pfe_entry_t    entry
);
  import pfe_pkg::*;

  localparam int PosW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CntW = $clog2(MAX_VARINT_BYTES);
  localparam int AccW = 35;
  localparam logic [24:0] MaxLen = 25'(MAX_MESSAGE_BYTES);

  localparam logic [2:0] PH_TAG           = 3'd0;
  localparam logic [2:0] PH_VALUE         = 3'd1;
  localparam logic [2:0] PH_LEN           = 3'd2;
  localparam logic [2:0] PH_CONTENT_FIRST = 3'd3;
  localparam logic [2:0] PH_CONTENT       = 3'd4;
  localparam logic [2:0] PH_SKIP          = 3'd5;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  logic [2:0]      phase;
  logic [AccW-1:0] acc;
  logic            acc_hi;
  logic [CntW-1:0] cnt;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] total;
  logic [PosW-1:0] btc;
  logic [31:0]     fnum;
  logic            sel_valid;
  logic            sel_bit;
  logic            stopped;
  logic [1:0]      stop_status;

  logic [2:0]      phase_next;
  logic [AccW-1:0] acc_next;
  logic            acc_hi_next;
  logic [CntW-1:0] cnt_next;
  logic [PosW-1:0] pos_next;
  logic [PosW-1:0] total_next;
  logic [PosW-1:0] btc_next;
  logic [31:0]     fnum_next;
  logic            sel_valid_next;
  logic            sel_bit_next;
  logic            stopped_next;
  logic [1:0]      stop_status_next;

  // state as seen after a message start is applied
  logic [2:0]      b_phase;
  logic [AccW-1:0] b_acc;
  logic            b_hi;
  logic [CntW-1:0] b_cnt;
  logic [PosW-1:0] b_pos;
  logic [PosW-1:0] b_total;
  logic [PosW-1:0] b_btc;
  logic [31:0]     b_fnum;
  logic            b_sel_valid;
  logic            b_sel_bit;
  logic            b_stopped;
  logic [1:0]      b_stop_status;

  logic [24:0]     len_sat;
  logic            active;
  logic [PosW-1:0] rem;
  logic [5:0]      sh;
  logic [AccW-1:0] acc_add;
  logic            hi_add;
  logic [AccW-1:0] v;
  logic            v_hi;
  logic            v_done;
  logic            v_over;
  logic [CntW-1:0] cnt_inc;
  logic [PosW-1:0] btc_dec;
  logic            match0;
  logic            match1;
  logic            at_end;

  always_comb begin
    len_sat = ({1'b0, message_length} > MaxLen) ? MaxLen : {1'b0, message_length};
    if (message_start) begin
      b_phase       = PH_TAG;
      b_acc         = '0;
      b_hi          = 1'b0;
      b_cnt         = '0;
      b_pos         = '0;
      b_total       = PosW'(len_sat);
      b_btc         = '0;
      b_fnum        = '0;
      b_sel_valid   = 1'b0;
      b_sel_bit     = 1'b0;
      b_stopped     = 1'b0;
      b_stop_status = STATUS_CLEAN;
    end else begin
      b_phase       = phase;
      b_acc         = acc;
      b_hi          = acc_hi;
      b_cnt         = cnt;
      b_pos         = pos;
      b_total       = total;
      b_btc         = btc;
      b_fnum        = fnum;
      b_sel_valid   = sel_valid;
      b_sel_bit     = sel_bit;
      b_stopped     = stopped;
      b_stop_status = stop_status;
    end

    active = b_pos < b_total;
    pos_next = active ? b_pos + 1'b1 : b_pos;
    rem = b_total - pos_next;
    at_end = active && (pos_next == b_total);

    // varint accumulation; bits at 35 and up only matter as nonzero
    sh = 6'(b_cnt) * 6'd7;
    acc_add = (int'(b_cnt) < 5) ? (AccW'(data_byte[6:0]) << sh) : '0;
    hi_add = (int'(b_cnt) >= 5) &&
             ((int'(b_cnt) == 9) ? data_byte[0] : (|data_byte[6:0]));
    v = b_acc | acc_add;
    v_hi = b_hi | hi_add;
    v_done = !data_byte[7] || (int'(b_cnt) == MAX_VARINT_BYTES - 1);
    cnt_inc = b_cnt + 1'b1;
    v_over = v_hi || (|v[AccW-1:PosW]) || (v[PosW-1:0] > rem);
    btc_dec = (b_btc != '0) ? b_btc - 1'b1 : b_btc;
    match0 = b_fnum == first_field_number;
    match1 = b_fnum == second_field_number;

    phase_next       = b_phase;
    acc_next         = b_acc;
    acc_hi_next      = b_hi;
    cnt_next         = b_cnt;
    total_next       = b_total;
    btc_next         = b_btc;
    fnum_next        = b_fnum;
    sel_valid_next   = b_sel_valid;
    sel_bit_next     = b_sel_bit;
    stopped_next     = b_stopped;
    stop_status_next = b_stop_status;

    entry = '0;

    if (active && !b_stopped) begin
      unique case (b_phase)
        PH_TAG, PH_VALUE, PH_LEN: begin
          if (!v_done) begin
            acc_next    = v;
            acc_hi_next = v_hi;
            cnt_next    = cnt_inc;
          end else begin
            acc_next    = '0;
            acc_hi_next = 1'b0;
            cnt_next    = '0;
            if (b_phase == PH_VALUE) begin
              phase_next = PH_TAG;
            end else if (b_phase == PH_TAG) begin
              fnum_next = v[34:3];
              unique case (v[2:0])
                WT_VARINT: phase_next = PH_VALUE;
                WT_LEN:    phase_next = PH_LEN;
                WT_FIXED32: begin
                  phase_next = PH_SKIP;
                  btc_next   = PosW'(4);
                end
                WT_FIXED64: begin
                  phase_next = PH_SKIP;
                  btc_next   = PosW'(8);
                end
                default: begin
                  stopped_next     = 1'b1;
                  stop_status_next = STATUS_BAD_WIRE;
                end
              endcase
            end else if (v_over) begin
              stopped_next     = 1'b1;
              stop_status_next = STATUS_OVERRUN;
            end else begin
              sel_valid_next = match0 || match1;
              sel_bit_next   = !match0;
              if (v[PosW-1:0] == '0) begin
                phase_next      = PH_TAG;
                entry.has_field = match0 || match1;
                entry.kind      = KIND_EMPTY;
                entry.sel       = !match0;
                entry.first     = 1'b1;
                entry.last      = 1'b1;
              end else begin
                btc_next   = v[PosW-1:0];
                phase_next = PH_CONTENT_FIRST;
              end
            end
          end
        end
        PH_CONTENT_FIRST, PH_CONTENT: begin
          btc_next        = btc_dec;
          entry.has_field = b_sel_valid;
          entry.kind      = KIND_CONTENT;
          entry.sel       = b_sel_bit;
          entry.content   = data_byte;
          entry.first     = b_phase == PH_CONTENT_FIRST;
          entry.last      = btc_dec == '0;
          phase_next      = (btc_dec == '0) ? PH_TAG : PH_CONTENT;
        end
        PH_SKIP: begin
          btc_next = btc_dec;
          if (btc_dec == '0) begin
            phase_next = PH_TAG;
          end
        end
        default: begin
          phase_next = b_phase;
        end
      endcase
    end

    entry.has_done = at_end;
    if (stopped_next) begin
      entry.status = stop_status_next;
    end else if (phase_next == PH_TAG && cnt_next == '0) begin
      entry.status = STATUS_CLEAN;
    end else begin
      entry.status = STATUS_MID;
    end
    if (!at_end) begin
      entry.status = STATUS_CLEAN;
    end

    push = in_fire && (entry.has_field || entry.has_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TAG;
      acc         <= '0;
      acc_hi      <= 1'b0;
      cnt         <= '0;
      pos         <= '0;
      total       <= '0;
      btc         <= '0;
      fnum        <= '0;
      sel_valid   <= 1'b0;
      sel_bit     <= 1'b0;
      stopped     <= 1'b0;
      stop_status <= STATUS_CLEAN;
    end else if (in_fire) begin
      phase       <= phase_next;
      acc         <= acc_next;
      acc_hi      <= acc_hi_next;
      cnt         <= cnt_next;
      pos         <= pos_next;
      total       <= total_next;
      btc         <= btc_next;
      fnum        <= fnum_next;
      sel_valid   <= sel_valid_next;
      sel_bit     <= sel_bit_next;
      stopped     <= stopped_next;
      stop_status <= stop_status_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfe_queue.sv =====
// Short queue of classified entries between the front and back ends.
// Depends on pfe_pkg for the entry type.
`default_nettype none

module pfe_queue #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  pfe_pkg::pfe_entry_t  push_entry,
  output logic                 full,
  output logic                 head_valid,
  output pfe_pkg::pfe_entry_t  head,
  input  wire                  pop
);
  import pfe_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  pfe_entry_t      slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = count == CntW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfe_back.sv =====
// Back end: splits queue entries into output beats behind an output register.
// Depends on pfe_pkg for the entry and beat types.
`default_nettype none

module pfe_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  head_valid,
  input  pfe_pkg::pfe_entry_t  head,
  output logic                 pop,
  output logic                 out_valid,
  output pfe_pkg::pfe_beat_t   out_beat,
  input  wire                  out_ready
);
  import pfe_pkg::*;

  logic field_sent;
  logic out_free;
  logic load_field;
  logic load_done;

  assign out_free   = !out_valid || out_ready;
  assign load_field = out_free && head_valid && head.has_field && !field_sent;
  assign load_done  = out_free && head_valid && !load_field;
  // retire the entry with its final beat
  assign pop        = load_done || (load_field && !head.has_done);

  always_ff @(posedge clk) begin
    if (load_field) begin
      out_beat.kind    <= head.kind;
      out_beat.sel     <= head.sel;
      out_beat.content <= head.content;
      out_beat.first   <= head.first;
      out_beat.last    <= head.last;
      out_beat.status  <= STATUS_CLEAN;
    end else if (load_done) begin
      out_beat.kind    <= KIND_DONE;
      out_beat.sel     <= 1'b0;
      out_beat.content <= '0;
      out_beat.first   <= 1'b0;
      out_beat.last    <= 1'b0;
      out_beat.status  <= head.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      field_sent <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= head_valid;
      end
      if (load_field && head.has_done) begin
        field_sent <= 1'b1;
      end else if (load_done) begin
        field_sent <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/protobuf_field_extractor_unit.sv =====
// Top level of the protobuf field extractor: stream ports, APB registers,
// and the front end, entry queue and back end. Depends on pfe_pkg.
`default_nettype none

// Parses a protobuf message body one byte per beat and streams out the content
// bytes of two chosen field numbers, then a done beat with the parse status.
// The input takes one byte per clock while the queue is not full: tag, length
// and skip handling all settle in the front end's combinational update. Each
// byte yields zero, one or two output beats; the last byte of a message that
// also gives a content byte or an empty-field result needs two. A queue of
// QUEUE_DEPTH entries lets input and output stall independently; tready drops
// only when that queue is full. Field number registers are at byte address 0
// and 4.
module protobuf_field_extractor_unit #(
  parameter int MAX_MESSAGE_BYTES = 8388608,
  parameter int MAX_VARINT_BYTES  = 10,
  parameter int QUEUE_DEPTH       = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // data_byte[7:0], message_length[31:8]
  input  wire  [0:0]  s_axis_tuser,   // message_start[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // content_byte[7:0], parse_status[9:8], zero
  output logic [3:0]  m_axis_tuser,   // result_kind[1:0], field_select[2],
                                      // first_of_field[3]
  output logic        m_axis_tlast,   // last_of_field
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfe_pkg::*;

  logic [31:0] first_field_number;
  logic [31:0] second_field_number;
  logic        cfg_write;
  logic        in_fire;
  logic        push;
  pfe_entry_t  push_entry;
  logic        full;
  logic        head_valid;
  pfe_entry_t  head;
  logic        pop;
  pfe_beat_t   out_beat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_field_number  <= 32'd4;
      second_field_number <= 32'd6;
    end else if (cfg_write) begin
      if (paddr[2] == REG_FIRST_FIELD) begin
        first_field_number <= pwdata;
      end else begin
        second_field_number <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_SECOND_FIELD) ? second_field_number : first_field_number;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  pfe_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .in_fire            (in_fire),
    .data_byte          (s_axis_tdata[7:0]),
    .message_start      (s_axis_tuser[0]),
    .message_length     (s_axis_tdata[31:8]),
    .first_field_number (first_field_number),
    .second_field_number(second_field_number),
    .push               (push),
    .entry              (push_entry)
  );

  pfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_beat  (out_beat),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {6'b0, out_beat.status, out_beat.content};
  assign m_axis_tuser = {out_beat.first, out_beat.sel, out_beat.kind};
  assign m_axis_tlast = out_beat.last;

endmodule

`default_nettype wire
